FILE: rtl/mbps_pkg.sv
// Shared types and constants for the masked byte pattern search core.
// No dependencies; imported by masked_byte_pattern_search_core.
`timescale 1ns / 1ps

package mbps_pkg;

  localparam int MAX_PATTERN_BYTES_DEF = 16;
  localparam int OFFSET_BITS_DEF       = 32;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 64;
  localparam int PAT_WORD_BITS  = 64;
  localparam int MASK_BITS      = 16;
  localparam int LEN_BITS       = 5;
  localparam int MATCH_OFS_BITS = 32;

  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

  localparam cfg_index_t CFG_PATTERN_LOW  = 2'd0;
  localparam cfg_index_t CFG_PATTERN_HIGH = 2'd1;
  localparam cfg_index_t CFG_CARE_MASK    = 2'd2;
  localparam cfg_index_t CFG_PATTERN_LEN  = 2'd3;

  localparam logic [15:0] CARE_MASK_RESET = 16'hFFFF;
  localparam logic [4:0]  PATTERN_LEN_RESET = 5'd1;

  localparam logic STATUS_FOUND  = 1'b0;
  localparam logic STATUS_ABSENT = 1'b1;

endpackage

FILE: rtl/masked_byte_pattern_search_core.sv
// Masked byte pattern search core: window compare, region tracking and output buffering.
// Depends on mbps_pkg.
`timescale 1ns / 1ps

// Takes one byte of a region per beat and reports the first offset at which the
// configured pattern (up to MAX_PATTERN_BYTES bytes, care mask selects which
// positions must match) lines up with the stream. Each region gives exactly one
// result: found with the start offset, or not found at the region's last byte.
// Throughput is one beat per clock while in_stall is low: all window positions are
// compared in parallel against the incoming byte and the last MAX_PATTERN_BYTES-1
// bytes, and the result is registered. An output register plus one skid entry keep
// input acceptance going while a result waits; in_stall rises only when both are
// full. Write configuration only while no beat is in flight.
module masked_byte_pattern_search_core #(
  parameter int MAX_PATTERN_BYTES = mbps_pkg::MAX_PATTERN_BYTES_DEF,
  parameter int OFFSET_BITS       = mbps_pkg::OFFSET_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration
  input  logic                                 cfg_wr_en,
  input  logic [mbps_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [mbps_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
  // input beats
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [7:0]                           in_data_byte,
  input  logic                                 in_first_of_region,
  input  logic                                 in_last_of_region,
  // results
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_status,
  output logic [mbps_pkg::MATCH_OFS_BITS-1:0]  out_match_offset
);
  import mbps_pkg::*;

  localparam int WIN_DEPTH = MAX_PATTERN_BYTES - 1;
  localparam int HIST_BITS = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

  // ---------------- configuration ----------------
  logic [PAT_WORD_BITS-1:0] pat_lo_r, pat_hi_r;
  logic [MASK_BITS-1:0]     care_r;
  logic [LEN_BITS-1:0]      len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r <= '0;
      pat_hi_r <= '0;
      care_r   <= CARE_MASK_RESET;
      len_r    <= PATTERN_LEN_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_PATTERN_LOW:  pat_lo_r <= cfg_wdata;
        CFG_PATTERN_HIGH: pat_hi_r <= cfg_wdata;
        CFG_CARE_MASK:    care_r   <= cfg_wdata[MASK_BITS-1:0];
        CFG_PATTERN_LEN:  len_r    <= cfg_wdata[LEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // clamp length into 1..MAX_PATTERN_BYTES
  logic [LEN_BITS-1:0] used_len;
  logic [LEN_BITS-1:0] len_m1;
  always_comb begin
    if (len_r == '0)
      used_len = LEN_BITS'(1);
    else if (len_r > LEN_BITS'(MAX_PATTERN_BYTES))
      used_len = LEN_BITS'(MAX_PATTERN_BYTES);
    else
      used_len = len_r;
    len_m1 = used_len - LEN_BITS'(1);
  end

  // ---------------- region state ----------------
  logic [7:0]             win_r [WIN_DEPTH];   // newest at entry 0
  logic [OFFSET_BITS-1:0] seen_r, seen_nxt;
  logic                   done_r, done_nxt;

  logic acc;
  assign acc = in_valid && !in_stall;

  // hist[0] is the current byte, hist[j] the byte j beats back
  logic [7:0] hist [MAX_PATTERN_BYTES];
  always_comb begin
    hist[0] = in_data_byte;
    for (int j = 1; j < MAX_PATTERN_BYTES; j++)
      hist[j] = win_r[j-1];
  end

  logic [2*PAT_WORD_BITS-1:0] pat_all;
  assign pat_all = {pat_hi_r, pat_lo_r};

  logic [MAX_PATTERN_BYTES-1:0] pos_ok;
  always_comb begin
    logic [LEN_BITS-1:0] back;
    for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
      back = len_m1 - LEN_BITS'(k);
      if (LEN_BITS'(k) < used_len && care_r[k])
        pos_ok[k] = (hist[back[HIST_BITS-1:0]] == pat_all[8*k +: 8]);
      else
        pos_ok[k] = 1'b1;
    end
  end

  logic [OFFSET_BITS-1:0] seen_eff, len_m1_ext, ofs_full;
  logic                   done_eff, hit, miss, res_vld;

  always_comb begin
    seen_eff   = in_first_of_region ? '0 : seen_r;
    done_eff   = in_first_of_region ? 1'b0 : done_r;
    len_m1_ext = OFFSET_BITS'(len_m1);
    hit        = !done_eff && (seen_eff >= len_m1_ext) && (&pos_ok);
    miss       = in_last_of_region && !done_eff && !hit;
    res_vld    = hit || miss;
    ofs_full   = seen_eff - len_m1_ext;

    if (in_last_of_region) begin
      seen_nxt = '0;
      done_nxt = 1'b0;
    end else begin
      seen_nxt = (&seen_eff) ? seen_eff : seen_eff + OFFSET_BITS'(1);
      done_nxt = done_eff || hit;
    end
  end

  logic [MATCH_OFS_BITS-1:0] res_ofs;
  generate
    if (OFFSET_BITS >= MATCH_OFS_BITS) begin : g_ofs_trunc
      assign res_ofs = hit ? ofs_full[MATCH_OFS_BITS-1:0] : '0;
    end else begin : g_ofs_ext
      assign res_ofs = hit ? MATCH_OFS_BITS'(ofs_full) : '0;
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < WIN_DEPTH; j++)
        win_r[j] <= '0;
      seen_r <= '0;
      done_r <= 1'b0;
    end else if (acc) begin
      win_r[0] <= in_data_byte;
      for (int j = 1; j < WIN_DEPTH; j++)
        win_r[j] <= win_r[j-1];
      seen_r <= seen_nxt;
      done_r <= done_nxt;
    end
  end

  // ---------------- output register + skid ----------------
  logic                      out_vld_r, skid_vld_r;
  logic                      out_stat_r, skid_stat_r;
  logic [MATCH_OFS_BITS-1:0] out_ofs_r, skid_ofs_r;
  logic                      out_take;

  assign out_take = out_vld_r && !out_stall;
  assign in_stall = skid_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      if (acc && res_vld) begin
        // skid is empty whenever a beat is accepted
        if (!out_vld_r || out_take) begin
          out_vld_r <= 1'b1;
        end else begin
          skid_vld_r <= 1'b1;
        end
      end else if (out_take) begin
        out_vld_r  <= skid_vld_r;
        skid_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && res_vld) begin
      if (!out_vld_r || out_take) begin
        out_stat_r <= miss ? STATUS_ABSENT : STATUS_FOUND;
        out_ofs_r  <= res_ofs;
      end else begin
        skid_stat_r <= miss ? STATUS_ABSENT : STATUS_FOUND;
        skid_ofs_r  <= res_ofs;
      end
    end else if (out_take && skid_vld_r) begin
      out_stat_r <= skid_stat_r;
      out_ofs_r  <= skid_ofs_r;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_status       = out_stat_r;
  assign out_match_offset = out_ofs_r;

  // ---------------- assertions ----------------
  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid entry held while output register empty");

  a_hit_sets_done: assert property (@(posedge clk) disable iff (!rst_n)
    acc && hit && !in_last_of_region |=> done_r)
    else $error("match did not close the region search");

  a_region_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_last_of_region |=> (seen_r == '0) && !done_r)
    else $error("region end did not clear search state");

  a_no_hit_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    done_eff |-> !res_vld)
    else $error("second result produced in a region");

endmodule

FILE: dv/masked_byte_pattern_search_core_tb.sv
// Self-checking testbench for masked_byte_pattern_search_core: directed and random
// byte regions against an in-bench scan predictor. Depends on mbps_pkg and the core RTL.
`timescale 1ns / 1ps

module masked_byte_pattern_search_core_tb;
  import mbps_pkg::*;

  localparam int WIN_DEPTH    = MAX_PATTERN_BYTES_DEF - 1;
  localparam int RAND_PHASES  = 10;
  localparam int PHASE_BEATS  = 115;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic                      status;
    logic [MATCH_OFS_BITS-1:0] offset;
  } scan_result_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_wr_en = 1'b0;
  cfg_index_t                cfg_index = CFG_PATTERN_LOW;
  logic [CFG_DATA_BITS-1:0]  cfg_wdata = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [7:0]                in_data_byte = '0;
  logic                      in_first_of_region = 1'b0;
  logic                      in_last_of_region = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic                      out_status;
  logic [MATCH_OFS_BITS-1:0] out_match_offset;

  masked_byte_pattern_search_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .in_first_of_region (in_first_of_region),
    .in_last_of_region  (in_last_of_region),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_match_offset   (out_match_offset)
  );

  // Mirror of the configuration registers and the scan state
  logic [2*PAT_WORD_BITS-1:0] pattern_q;
  logic [MASK_BITS-1:0]       care_mask_q;
  logic [LEN_BITS-1:0]        pattern_len_q;
  logic [7:0]                 window_q [WIN_DEPTH];
  logic [OFFSET_BITS_DEF-1:0] bytes_seen_q;
  bit                         search_done_q;

  scan_result_t pending_results[$];

  int  mismatches = 0;
  int  beats_sent = 0;
  int  found_seen = 0;
  int  missed_seen = 0;
  int  settings_used = 0;
  bit  in_quiet = 1'b0;
  bit  out_quiet = 1'b0;
  bit  hold_req = 1'b0;
  int  hold_left = 0;
  int  stall_run = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic int unsigned effective_len();
    if (pattern_len_q == 0) return 1;
    if (pattern_len_q > MAX_PATTERN_BYTES_DEF) return MAX_PATTERN_BYTES_DEF;
    return 32'(pattern_len_q);
  endfunction

  function automatic logic [7:0] pattern_byte(int unsigned k);
    return pattern_q[8*k +: 8];
  endfunction

  // Advance the scan state by one byte and queue the result it decides, if any
  function automatic void scan_byte(logic [7:0] b, logic first, logic last);
    int unsigned  n;
    int           k;
    bit           hit;
    logic [7:0]   d;
    scan_result_t r;
    n = effective_len();
    if (first) begin
      bytes_seen_q = '0;
      search_done_q = 1'b0;
    end
    hit = 1'b0;
    if (!search_done_q && bytes_seen_q >= n - 1) begin
      hit = 1'b1;
      for (k = 0; k < n; k++) begin
        if (care_mask_q[k]) begin
          if (k == n - 1) d = b;
          else d = window_q[n - 2 - k];
          if (d != pattern_byte(k)) hit = 1'b0;
        end
      end
    end
    if (hit) begin
      r.status = STATUS_FOUND;
      r.offset = bytes_seen_q - (n - 1);
      search_done_q = 1'b1;
      pending_results.push_back(r);
    end else if (last && !search_done_q) begin
      r.status = STATUS_ABSENT;
      r.offset = '0;
      pending_results.push_back(r);
    end
    for (k = WIN_DEPTH - 1; k > 0; k--) window_q[k] = window_q[k-1];
    window_q[0] = b;
    if (bytes_seen_q != '1) bytes_seen_q++;
    if (last) begin
      bytes_seen_q = '0;
      search_done_q = 1'b0;
    end
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int pick_gap(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (out_quiet) begin
      out_stall <= 1'b0;
    end else if (stall_run > 0) begin
      stall_run--;
    end else begin
      stall_run = pick_gap(1'b0);
      out_stall <= ($urandom_range(0, 2) == 0);
    end
  end

  always @(posedge clk) begin
    scan_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches < 40)
          $display("%0t: result beat with none expected: status %0d offset %0d",
                   $time, out_status, out_match_offset);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_status !== exp_r.status) begin
          mismatches++;
          if (mismatches < 40)
            $display("%0t: status mismatch: expected %0d, got %0d",
                     $time, exp_r.status, out_status);
        end
        if (out_match_offset !== exp_r.offset) begin
          mismatches++;
          if (mismatches < 40)
            $display("%0t: match_offset mismatch: expected %0d, got %0d",
                     $time, exp_r.offset, out_match_offset);
        end
        if (exp_r.status == STATUS_FOUND) found_seen++;
        else missed_seen++;
      end
    end
  end

  task automatic send_beat(logic [7:0] b, logic first, logic last);
    int gap;
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_first_of_region <= first;
    in_last_of_region <= last;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    scan_byte(b, first, last);
    beats_sent++;
    gap = pick_gap(in_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and let every expected result arrive before returning
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_beat(cfg_index_t idx, logic [CFG_DATA_BITS-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
  endtask

  // sel: bit 0 low pattern word, bit 1 high word, bit 2 care mask, bit 3 length
  task automatic write_config(logic [3:0] sel, logic [63:0] lo, logic [63:0] hi,
                              logic [MASK_BITS-1:0] mask, logic [LEN_BITS-1:0] len);
    wait_idle();
    if (sel[0]) begin
      cfg_beat(CFG_PATTERN_LOW, lo);
      pattern_q[PAT_WORD_BITS-1:0] = lo;
    end
    if (sel[1]) begin
      cfg_beat(CFG_PATTERN_HIGH, hi);
      pattern_q[2*PAT_WORD_BITS-1:PAT_WORD_BITS] = hi;
    end
    if (sel[2]) begin
      cfg_beat(CFG_CARE_MASK, CFG_DATA_BITS'(mask));
      care_mask_q = mask;
    end
    if (sel[3]) begin
      cfg_beat(CFG_PATTERN_LEN, CFG_DATA_BITS'(len));
      pattern_len_q = len;
    end
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  // Region content leans on pattern bytes and 00/FF so partial matches are common
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 3))
      0, 1:    return pattern_byte($urandom_range(0, effective_len() - 1));
      2:       return 8'($urandom);
      default: return $urandom_range(0, 1) ? 8'h00 : 8'hFF;
    endcase
  endfunction

  task automatic scan_region();
    logic [7:0]  region_bytes[];
    int          len;
    int          r;
    int          pos;
    int unsigned n;
    bit          broken;
    logic        first;
    logic        last;
    r = $urandom_range(0, 99);
    if (r < 70) len = $urandom_range(1, 24);
    else if (r < 96) len = $urandom_range(25, 64);
    else len = $urandom_range(100, 300);
    region_bytes = new[len];
    foreach (region_bytes[i]) region_bytes[i] = pick_byte();
    n = effective_len();
    if (len >= n && $urandom_range(0, 1)) begin
      pos = $urandom_range(0, len - n);
      for (int k = 0; k < n; k++)
        if (care_mask_q[k]) region_bytes[pos+k] = pattern_byte(k);
    end
    broken = ($urandom_range(0, 9) == 0);
    foreach (region_bytes[i]) begin
      if (broken) begin
        first = ($urandom_range(0, 7) == 0);
        last = ($urandom_range(0, 7) == 0);
      end else begin
        first = (i == 0);
        last = (i == len - 1);
      end
      send_beat(region_bytes[i], first, last);
    end
  endtask

  task automatic reset_scan_model();
    pattern_q = '0;
    care_mask_q = CARE_MASK_RESET;
    pattern_len_q = PATTERN_LEN_RESET;
    foreach (window_q[i]) window_q[i] = 8'h00;
    bytes_seen_q = '0;
    search_done_q = 1'b0;
  endtask

  // Reset values: one-byte pattern 00; also a region opened only by the prior region's end
  task automatic test_default_config();
    send_beat(8'h55, 1'b1, 1'b0);
    send_beat(8'h00, 1'b0, 1'b0);
    send_beat(8'h00, 1'b0, 1'b1);
    send_beat(8'hFF, 1'b0, 1'b1);
  endtask

  // Length above the maximum acts as 16; middle bytes wildcarded, match lands on final byte
  task automatic test_full_length_wildcards();
    write_config(4'b1111, 64'h0123_4567_89AB_CDFF, 64'hFFED_CBA9_8765_4321,
                 16'h8001, 5'd31);
    send_beat(8'hFF, 1'b1, 1'b0);
    for (int i = 0; i < 14; i++) send_beat(8'($urandom), 1'b0, 1'b0);
    send_beat(8'hFF, 1'b0, 1'b1);
  endtask

  // Mid-region restart leaves too few bytes; mask bits past the length are don't-care
  task automatic test_restart_short_region();
    write_config(4'b1101, 64'h0000_0000_0056_3412, '0, 16'hFFFA, 5'd3);
    send_beat(8'h34, 1'b1, 1'b0);
    send_beat(8'h34, 1'b1, 1'b0);
    send_beat(8'h99, 1'b0, 1'b1);
  endtask

  task automatic test_zero_length();
    write_config(4'b1000, '0, '0, '0, 5'd0);
    send_beat(8'h12, 1'b1, 1'b1);
  endtask

  task automatic test_random_scans();
    logic [63:0]          lo;
    logic [63:0]          hi;
    logic [MASK_BITS-1:0] mask;
    logic [LEN_BITS-1:0]  len;
    int                   start;
    int                   r;
    for (int p = 0; p < RAND_PHASES; p++) begin
      lo = {$urandom, $urandom};
      hi = {$urandom, $urandom};
      r = $urandom_range(0, 9);
      if (r < 5) len = 5'($urandom_range(1, 4));
      else if (r < 8) len = 5'($urandom_range(5, 16));
      else if (r < 9) len = 5'd16;
      else len = $urandom_range(0, 1) ? 5'd0 : 5'($urandom_range(17, 31));
      case ($urandom_range(0, 4))
        0, 1:    mask = 16'hFFFF;
        2:       mask = 16'($urandom);
        3:       mask = 16'($urandom) | 16'($urandom);
        default: mask = 16'h0000;
      endcase
      if (p == 0) begin
        lo = '0;
        hi = '0;
        mask = 16'hFFFF;
        len = 5'd2;
      end else if (p == 1) begin
        lo = '1;
        hi = '1;
        mask = 16'hFFFF;
        len = 5'd16;
      end
      write_config(4'b1111, lo, hi, mask, len);
      in_quiet = ($urandom_range(0, 3) == 0);
      out_quiet = ($urandom_range(0, 3) == 0);
      start = beats_sent;
      while (beats_sent - start < PHASE_BEATS) scan_region();
    end
    in_quiet = 1'b0;
    out_quiet = 1'b0;
  endtask

  // Receiver holds off for a long stretch while one-byte regions keep coming
  task automatic test_output_backpressure();
    write_config(4'b1111, {$urandom, $urandom}, '0, 16'hFFFF, 5'd1);
    in_quiet = 1'b1;
    hold_req = 1'b1;
    for (int i = 0; i < 60; i++) send_beat(8'($urandom), 1'b1, 1'b1);
    in_quiet = 1'b0;
  endtask

  initial begin
    reset_scan_model();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_config();
    test_full_length_wildcards();
    test_restart_short_region();
    test_zero_length();
    test_random_scans();
    test_output_backpressure();
    wait_idle();
    $display("Scanned %0d beats over %0d register settings: %0d found, %0d not found results",
             beats_sent, settings_used, found_seen, missed_seen);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
